// ===== src/tccs_pkg.sv =====
// shared types, constants and the arctangent table of the tilt compass
`default_nettype none
package tccs_pkg;

  // default build values
  localparam int CordicStepsDef = 16;
  localparam int SampleBitsDef  = 16;

  // datapath widths
  localparam int CordW = 48;
  localparam int ZW    = 27;
  localparam int AngW  = 15;
  localparam int TrigW = 26;
  localparam int ProdW = 52;
  localparam int HW    = 44;
  localparam int MagW  = 35;

  // angle constants in Q13, inverse cordic gain in Q24
  localparam logic signed [16:0] HalfPiQ13      = 17'sd12868;
  localparam logic signed [16:0] PiQ13          = 17'sd25736;
  localparam logic signed [16:0] ThreeHalfPiQ13 = 17'sd38604;
  localparam logic signed [16:0] TwoPiQ13       = 17'sd51472;
  localparam logic [23:0]        InvGainQ24     = 24'd10188013;
  localparam logic signed [ZW-1:0] GainStart    = 27'sd10188013;

  // sector boundaries in Q13
  localparam logic [15:0] SecA = 16'd2048;
  localparam logic [15:0] SecB = 16'd9011;
  localparam logic [15:0] SecC = 16'd17613;
  localparam logic [15:0] SecD = 16'd24166;
  localparam logic [15:0] SecE = 16'd29491;
  localparam logic [15:0] SecF = 16'd36045;
  localparam logic [15:0] SecG = 16'd42598;
  localparam logic [15:0] SecH = 16'd47514;

  // last product/accumulate pair of the tilt rotation
  localparam logic [2:0] MulLast = 3'd6;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_TILT_INIT,
    OP_VEC,
    OP_MAG_MUL,
    OP_ATAN_INIT,
    OP_ATAN_DONE,
    OP_SC_INIT,
    OP_ROT,
    OP_SC_STORE,
    OP_MUL,
    OP_ACC,
    OP_HEAD_INIT,
    OP_HEAD_DONE,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       sel;   // 0 pitch, 1 roll
    logic [4:0] idx;   // cordic iteration
    logic [2:0] k;     // product index
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } stat_t;

  // atan(2^-i) in Q24
  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 27'sd13176795;
      5'd1:  v = 27'sd7778716;
      5'd2:  v = 27'sd4110060;
      5'd3:  v = 27'sd2086331;
      5'd4:  v = 27'sd1047214;
      5'd5:  v = 27'sd524117;
      5'd6:  v = 27'sd262123;
      5'd7:  v = 27'sd131069;
      5'd8:  v = 27'sd65536;
      5'd9:  v = 27'sd32768;
      5'd10: v = 27'sd16384;
      5'd11: v = 27'sd8192;
      5'd12: v = 27'sd4096;
      5'd13: v = 27'sd2048;
      5'd14: v = 27'sd1024;
      5'd15: v = 27'sd512;
      5'd16: v = 27'sd256;
      5'd17: v = 27'sd128;
      5'd18: v = 27'sd64;
      5'd19: v = 27'sd32;
      5'd20: v = 27'sd16;
      5'd21: v = 27'sd8;
      5'd22: v = 27'sd4;
      5'd23: v = 27'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/tccs_ctrl.sv =====
// sequencer of the tilt compass: steps the shared cordic and multiplier
`default_nettype none
module tccs_ctrl import tccs_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire logic  out_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam logic [IW-1:0] ILast = IW'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TILT_INIT,
    S_TILT_VEC,
    S_MAG_MUL,
    S_ATAN_INIT,
    S_ATAN_VEC,
    S_ATAN_DONE,
    S_SC_INIT,
    S_SC_ROT,
    S_SC_STORE,
    S_MUL,
    S_ACC,
    S_HEAD_INIT,
    S_HEAD_VEC,
    S_HEAD_DONE,
    S_OUT
  } state_t;

  state_t        state;
  logic [IW-1:0] i;
  logic          sel;
  logic [2:0]    k;
  logic          slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !stat.out_full || !out_stall;

  // command decode
  always_comb begin
    cmd.sel = sel;
    cmd.idx = 5'(i);
    cmd.k   = k;
    unique case (state)
      S_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_TILT_INIT: cmd.op = OP_TILT_INIT;
      S_TILT_VEC:  cmd.op = OP_VEC;
      S_MAG_MUL:   cmd.op = OP_MAG_MUL;
      S_ATAN_INIT: cmd.op = OP_ATAN_INIT;
      S_ATAN_VEC:  cmd.op = OP_VEC;
      S_ATAN_DONE: cmd.op = OP_ATAN_DONE;
      S_SC_INIT:   cmd.op = OP_SC_INIT;
      S_SC_ROT:    cmd.op = OP_ROT;
      S_SC_STORE:  cmd.op = OP_SC_STORE;
      S_MUL:       cmd.op = OP_MUL;
      S_ACC:       cmd.op = OP_ACC;
      S_HEAD_INIT: cmd.op = OP_HEAD_INIT;
      S_HEAD_VEC:  cmd.op = OP_VEC;
      S_HEAD_DONE: cmd.op = OP_HEAD_DONE;
      S_OUT:       cmd.op = slot_free ? OP_OUT : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      sel   <= 1'b0;
      k     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sel   <= 1'b0;
            state <= S_TILT_INIT;
          end
        end
        S_TILT_INIT: begin
          i     <= '0;
          state <= S_TILT_VEC;
        end
        S_TILT_VEC: begin
          if (i == ILast) state <= S_MAG_MUL;
          else i <= i + 1'b1;
        end
        S_MAG_MUL:   state <= S_ATAN_INIT;
        S_ATAN_INIT: begin
          i     <= '0;
          state <= S_ATAN_VEC;
        end
        S_ATAN_VEC: begin
          if (i == ILast) state <= S_ATAN_DONE;
          else i <= i + 1'b1;
        end
        S_ATAN_DONE: begin
          if (sel) begin
            sel   <= 1'b0;
            state <= S_SC_INIT;
          end else begin
            sel   <= 1'b1;
            state <= S_TILT_INIT;
          end
        end
        S_SC_INIT: begin
          i     <= '0;
          state <= S_SC_ROT;
        end
        S_SC_ROT: begin
          if (i == ILast) state <= S_SC_STORE;
          else i <= i + 1'b1;
        end
        S_SC_STORE: begin
          if (sel) begin
            sel   <= 1'b0;
            k     <= '0;
            state <= S_MUL;
          end else begin
            sel   <= 1'b1;
            state <= S_SC_INIT;
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (k == MulLast) state <= S_HEAD_INIT;
          else begin
            k     <= k + 1'b1;
            state <= S_MUL;
          end
        end
        S_HEAD_INIT: begin
          i     <= '0;
          state <= S_HEAD_VEC;
        end
        S_HEAD_VEC: begin
          if (i == ILast) state <= S_HEAD_DONE;
          else i <= i + 1'b1;
        end
        S_HEAD_DONE: state <= S_OUT;
        S_OUT: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/tccs_dp.sv =====
// datapath of the tilt compass: shared cordic, multiplier, heading and led logic
`default_nettype none
module tccs_dp import tccs_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic signed [15:0] mag_x,
  input  wire logic signed [15:0] mag_y,
  input  wire logic signed [15:0] mag_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             heading,
  output logic signed [14:0]      pitch_angle,
  output logic signed [14:0]      roll_angle,
  output logic [7:0]              led_mask
);

  localparam int SW = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int SH = 16 - SW;

  function automatic logic signed [15:0] sx(input logic [15:0] f);
    logic [15:0] t;
    t = f << SH;
    return $signed(t) >>> SH;
  endfunction

  // sample registers
  logic signed [15:0] ax, ay, az, mx, my, mz;
  // cordic registers
  logic signed [CordW-1:0] cx, cy;
  logic signed [ZW-1:0]    cz;
  logic                    at_zero, at_edge, at_neg;
  // results and intermediates
  logic signed [AngW-1:0]  pitch_r, roll_r;
  logic signed [TrigW-1:0] sp, cp, sr, cr, t1;
  logic signed [ProdW-1:0] prod;
  logic signed [HW-1:0]    hx, hy;
  logic [15:0]             last_hd;
  logic [7:0]              leds;

  // combinational helpers
  logic signed [CordW-1:0] dx, dy, az_abs, num_ext, tilt_a;
  logic signed [ZW-1:0]    tab;
  logic signed [CordW-1:0] mpos;
  logic [MagW+23:0]        mprod;
  logic signed [27:0]      zr;
  logic signed [16:0]      q17;
  logic signed [AngW-1:0]  atan_q;
  logic signed [TrigW-1:0] mul_a, mul_b;
  logic signed [16:0]      h;
  logic [15:0]             h16;
  logic [7:0]              leds_next;
  logic signed [HW-1:0]    hx_abs, hy_abs;

  assign stat.out_full = out_valid;

  // cordic shifts and table
  always_comb begin
    dx      = cy >>> cmd.idx;
    dy      = cx >>> cmd.idx;
    tab     = atan_tab(cmd.idx);
    az_abs  = (az < 0) ? -CordW'(az) : CordW'(az);
    tilt_a  = cmd.sel ? CordW'(ax) : CordW'(ay);
    num_ext = cmd.sel ? CordW'(ay) : CordW'(ax);
    mpos    = (cx < 0) ? '0 : cx;
    mprod   = $unsigned(mpos[MagW-1:0]) * InvGainQ24;
  end

  // rounded and clamped arctangent with the degenerate cases
  always_comb begin
    zr  = (28'(cz) + 28'sd1024) >>> 11;
    q17 = zr[16:0];
    if (q17 > HalfPiQ13) q17 = HalfPiQ13;
    if (q17 < -HalfPiQ13) q17 = -HalfPiQ13;
    if (at_zero) atan_q = '0;
    else if (at_edge) atan_q = at_neg ? -AngW'(HalfPiQ13) : AngW'(HalfPiQ13);
    else atan_q = q17[AngW-1:0];
  end

  // multiplier operand select
  always_comb begin
    unique case (cmd.k)
      3'd0:    begin mul_a = TrigW'(mx); mul_b = cp; end
      3'd1:    begin mul_a = TrigW'(mz); mul_b = sp; end
      3'd2:    begin mul_a = sr;         mul_b = sp; end
      3'd3:    begin mul_a = TrigW'(mx); mul_b = t1; end
      3'd4:    begin mul_a = TrigW'(my); mul_b = cr; end
      3'd5:    begin mul_a = sr;         mul_b = cp; end
      3'd6:    begin mul_a = TrigW'(mz); mul_b = t1; end
      default: begin mul_a = '0;         mul_b = '0; end
    endcase
  end

  // heading from the quadrant rules
  always_comb begin
    hx_abs = (hx < 0) ? -hx : hx;
    hy_abs = (hx < 0) ? -hy : hy;
    h = $signed({1'b0, last_hd});
    if (hx > 0 && hy >= 0) h = 17'(atan_q);
    if (hx < 0) h = PiQ13 + 17'(atan_q);
    if (hx > 0 && hy <= 0) h = TwoPiQ13 + 17'(atan_q);
    if (hx == 0 && hy < 0) h = HalfPiQ13;
    if (hx == 0 && hy > 0) h = ThreeHalfPiQ13;
    h16 = h[15:0];
  end

  // sector led update
  always_comb begin
    priority if (h16 > SecA && h16 < SecB) leds_next = (leds & ~8'b0001_0100) | 8'b0000_1000;
    else if (h16 >= SecB && h16 < SecC) leds_next = (leds & ~8'b0000_1010) | 8'b0000_0100;
    else if (h16 >= SecC && h16 < SecD) leds_next = (leds & ~8'b0000_0101) | 8'b0000_0010;
    else if (h16 >= SecD && h16 < SecE) leds_next = (leds & ~8'b1000_0010) | 8'b0000_0001;
    else if (h16 >= SecE && h16 < SecF) leds_next = (leds & ~8'b0100_0001) | 8'b1000_0000;
    else if (h16 >= SecF && h16 < SecG) leds_next = (leds & ~8'b1010_0000) | 8'b0100_0000;
    else if (h16 >= SecG && h16 < SecH) leds_next = (leds & ~8'b0101_0000) | 8'b0010_0000;
    else if (h16 < SecA || h16 >= SecH) leds_next = (leds & ~8'b0010_1000) | 8'b0001_0000;
    else leds_next = leds;
  end

  // control state: stored heading, leds, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      last_hd   <= '0;
      leds      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_HEAD_DONE) begin
        last_hd <= h16;
        leds    <= leds_next;
      end
      if (cmd.op == OP_OUT) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        ax <= sx(accel_x);
        ay <= sx(accel_y);
        az <= sx(accel_z);
        mx <= sx(mag_x);
        my <= sx(mag_y);
        mz <= sx(mag_z);
      end
      OP_TILT_INIT: begin
        cx <= az_abs <<< 16;
        cy <= tilt_a <<< 16;
        cz <= '0;
      end
      OP_VEC: begin
        if (cy >= 0) begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + tab;
        end else begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - tab;
        end
      end
      OP_ROT: begin
        if (cz >= 0) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - tab;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + tab;
        end
      end
      OP_MAG_MUL: cx <= CordW'(mprod[MagW+23:24]);
      OP_ATAN_INIT: begin
        cy      <= num_ext <<< 16;
        cz      <= '0;
        at_zero <= (num_ext == 0);
        at_edge <= (cx <= 0);
        at_neg  <= (num_ext < 0);
      end
      OP_ATAN_DONE: begin
        if (cmd.sel) roll_r <= atan_q;
        else pitch_r <= atan_q;
      end
      OP_SC_INIT: begin
        cx <= CordW'(GainStart);
        cy <= '0;
        cz <= cmd.sel ? (ZW'(roll_r) <<< 11) : (ZW'(pitch_r) <<< 11);
      end
      OP_SC_STORE: begin
        if (cmd.sel) begin
          sr <= cy[TrigW-1:0];
          cr <= cx[TrigW-1:0];
        end else begin
          sp <= cy[TrigW-1:0];
          cp <= cx[TrigW-1:0];
        end
      end
      OP_MUL: prod <= mul_a * mul_b;
      OP_ACC: begin
        unique case (cmd.k)
          3'd0:    hx <= prod[HW-1:0];
          3'd1:    hx <= hx + prod[HW-1:0];
          3'd3:    hy <= prod[HW-1:0];
          3'd4:    hy <= hy + prod[HW-1:0];
          3'd6:    hy <= hy - prod[HW-1:0];
          default: t1 <= TrigW'(prod >>> 24);
        endcase
      end
      OP_HEAD_INIT: begin
        cx      <= CordW'(hx_abs);
        cy      <= CordW'(hy_abs);
        cz      <= '0;
        at_zero <= (hy_abs == 0);
        at_edge <= (hx_abs <= 0);
        at_neg  <= (hy_abs < 0);
      end
      OP_OUT: begin
        heading     <= last_hd;
        pitch_angle <= pitch_r;
        roll_angle  <= roll_r;
        led_mask    <= leds;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading <= 16'd51472))
    else $error("heading beyond two pi");
  a_out_set: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |=> out_valid)
    else $error("result not presented");
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868))
    else $error("pitch beyond half pi");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// ===== src/tilt_compensated_compass_sector.sv =====
// tilt compensated compass with eight-led sector display, top level
//
// Input channel (in_valid/in_stall) carries one accelerometer triple and one
// magnetometer triple per transfer. Output channel (out_valid/out_stall)
// carries heading (Q3.13, 0..2pi), pitch and roll (Q2.13) and the led mask.
// Pitch and roll come from cordic vectoring (root-sum-square then atan), the
// magnetometer vector is rotated with cordic sin/cos and resolved to a heading.
// One item at a time: before out_valid rises, the single shared cordic unit
// runs seven passes of CORDIC_STEPS iterations and the multiplier runs the
// seven multiply/accumulate pairs of the tilt rotation. A new transfer is
// taken only once the block has returned to idle.
// in_stall is low only while the block is idle.
// The result sits in an output register; the next input is taken while it
// waits, and the block holds its finished item until the slot frees.
// Reset (rst, synchronous) clears the stored heading to zero, turns all leds
// off and empties the output register.
`default_nettype none
module tilt_compensated_compass_sector import tccs_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef,
  parameter int SAMPLE_BITS  = SampleBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic signed [15:0] mag_x,
  input  wire logic signed [15:0] mag_y,
  input  wire logic signed [15:0] mag_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             heading,
  output logic signed [14:0]      pitch_angle,
  output logic signed [14:0]      roll_angle,
  output logic [7:0]              led_mask
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  tccs_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  tccs_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .accel_x    (accel_x),
    .accel_y    (accel_y),
    .accel_z    (accel_z),
    .mag_x      (mag_x),
    .mag_y      (mag_y),
    .mag_z      (mag_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .heading    (heading),
    .pitch_angle(pitch_angle),
    .roll_angle (roll_angle),
    .led_mask   (led_mask)
  );

endmodule
`default_nettype wire
